// ===== rtl/rover_mission_watchdog_macros.svh =====
// Assertion macros used by the checker file of the watchdog.
`ifndef ROVER_MISSION_WATCHDOG_MACROS_SVH
`define ROVER_MISSION_WATCHDOG_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RMW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rover watchdog check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RMW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rover watchdog check failed");

`endif

// ===== rtl/rmw_pkg.sv =====
package rmw_pkg;

    // Event codes carried by the opcode field.
    typedef enum logic [2:0] {
        OP_HEARTBEAT    = 3'd0,
        OP_ITEM_REACHED = 3'd1,
        OP_DISTANCE     = 3'd2,
        OP_WAYPOINT     = 3'd3,
        OP_GPS1         = 3'd4,
        OP_GPS2         = 3'd5,
        OP_TICK         = 3'd6
    } t_opcode;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STOP_SECONDS    = 3'd0;
    localparam logic [2:0] CFG_MIN_FIX_QUALITY = 3'd1;
    localparam logic [2:0] CFG_AUTO_MODE_CODE  = 3'd2;
    localparam logic [2:0] CFG_HOLD_MODE_CODE  = 3'd3;
    localparam logic [2:0] CFG_ROVER_TYPE_CODE = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] STOP_SECONDS_RST    = 16'd10;
    localparam logic [7:0]  MIN_FIX_QUALITY_RST = 8'd3;
    localparam logic [7:0]  AUTO_MODE_CODE_RST  = 8'd10;
    localparam logic [7:0]  HOLD_MODE_CODE_RST  = 8'd4;
    localparam logic [7:0]  ROVER_TYPE_CODE_RST = 8'd10;

    // Timeout in milliseconds: 65535 s times 1000 fits in 26 bits.
    localparam int          LIMIT_W      = 26;
    localparam logic [LIMIT_W-1:0] MS_PER_SECOND = LIMIT_W'(1000);
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(10000);

    // Other fixed values of the monitor.
    localparam logic [31:0] INIT_MODE       = 32'd16;
    localparam logic [7:0]  WRONG_WAY_ALERT = 8'd2;
    localparam logic [7:0]  COUNT_MAX       = 8'd255;

    // Sound flags.
    localparam logic [5:0] SND_LINK_GOOD = 6'b000001;
    localparam logic [5:0] SND_READY     = 6'b000010;
    localparam logic [5:0] SND_LINK_LOST = 6'b000100;
    localparam logic [5:0] SND_GPS_LOW   = 6'b001000;
    localparam logic [5:0] SND_EMERGENCY = 6'b010000;
    localparam logic [5:0] SND_WRONG_WAY = 6'b100000;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit_ms;
        logic [7:0]         min_fix_quality;
        logic [7:0]         auto_mode_code;
        logic [7:0]         hold_mode_code;
        logic [7:0]         rover_type_code;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] time_ms;
        logic [7:0]  vehicle_type;
        logic [31:0] mode_number;
        logic [15:0] waypoint_distance;
        logic [15:0] waypoint_index;
        logic [7:0]  fix_quality;
    } t_item;

    typedef struct packed {
        logic        power_on;
        logic        alarm_on;
        logic        mission_failed;
        logic        mode_request_valid;
        logic [7:0]  mode_request;
        logic        announce_valid;
        logic [31:0] announce_mode;
        logic [5:0]  sound_flags;
    } t_result;

endpackage

// ===== rtl/rmw_cfg.sv =====
module rmw_cfg
    import rmw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [2:0]  i_index,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    logic [LIMIT_W-1:0] r_limit_ms;
    logic [7:0]         r_min_fix_quality;
    logic [7:0]         r_auto_mode_code;
    logic [7:0]         r_hold_mode_code;
    logic [7:0]         r_rover_type_code;
    logic [LIMIT_W-1:0] n_limit_ms;

    // The stop time is kept in milliseconds so that the tick check is one compare.
    assign n_limit_ms = LIMIT_W'(i_data) * MS_PER_SECOND;

    // Register file; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_ms        <= LIMIT_RST;
            r_min_fix_quality <= MIN_FIX_QUALITY_RST;
            r_auto_mode_code  <= AUTO_MODE_CODE_RST;
            r_hold_mode_code  <= HOLD_MODE_CODE_RST;
            r_rover_type_code <= ROVER_TYPE_CODE_RST;
        end else if (i_wr) begin
            case (i_index)
                CFG_STOP_SECONDS:    r_limit_ms        <= n_limit_ms;
                CFG_MIN_FIX_QUALITY: r_min_fix_quality <= i_data[7:0];
                CFG_AUTO_MODE_CODE:  r_auto_mode_code  <= i_data[7:0];
                CFG_HOLD_MODE_CODE:  r_hold_mode_code  <= i_data[7:0];
                CFG_ROVER_TYPE_CODE: r_rover_type_code <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.limit_ms        = r_limit_ms;
    assign o_cfg.min_fix_quality = r_min_fix_quality;
    assign o_cfg.auto_mode_code  = r_auto_mode_code;
    assign o_cfg.hold_mode_code  = r_hold_mode_code;
    assign o_cfg.rover_type_code = r_rover_type_code;

endmodule

// ===== rtl/rmw_core.sv =====
module rmw_core
    import rmw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic        r_link_seen, r_ready_announced, r_distance_known, r_going_wrong_way;
    logic        r_failed_latch, r_power_relay, r_alarm_relay;
    logic [31:0] r_last_heartbeat_ms, r_last_progress_ms, r_current_mode;
    logic [15:0] r_last_distance, r_current_waypoint;
    logic [7:0]  r_wrong_way_count, r_gps1_quality, r_gps2_quality;

    logic        n_link_seen, n_ready_announced, n_distance_known, n_going_wrong_way;
    logic        n_failed_latch, n_power_relay, n_alarm_relay;
    logic [31:0] n_last_heartbeat_ms, n_last_progress_ms, n_current_mode;
    logic [15:0] n_last_distance, n_current_waypoint;
    logic [7:0]  n_wrong_way_count, n_gps1_quality, n_gps2_quality;

    logic [31:0] heartbeat_age, progress_age, limit_ms;
    logic [7:0]  best_fix;
    logic        is_auto, is_hold, link_lost, gps_lost, stalled;

    // Tick checks, all taken against the state before the event.
    assign limit_ms      = 32'(i_cfg.limit_ms);
    assign heartbeat_age = i_item.time_ms - r_last_heartbeat_ms;
    assign progress_age  = i_item.time_ms - r_last_progress_ms;
    assign best_fix      = (r_gps1_quality > r_gps2_quality) ? r_gps1_quality
                                                              : r_gps2_quality;
    assign is_auto   = (r_current_mode == 32'(i_cfg.auto_mode_code));
    assign is_hold   = (r_current_mode == 32'(i_cfg.hold_mode_code));
    assign link_lost = r_link_seen && (heartbeat_age >= limit_ms);
    assign gps_lost  = (best_fix < i_cfg.min_fix_quality);
    assign stalled   = (r_last_progress_ms != 32'd0) && (progress_age >= limit_ms);

    // Event decode: next state and the result of this event.
    always_comb begin
        logic progress;
        progress            = 1'b0;
        n_link_seen         = r_link_seen;
        n_ready_announced   = r_ready_announced;
        n_distance_known    = r_distance_known;
        n_going_wrong_way   = r_going_wrong_way;
        n_failed_latch      = r_failed_latch;
        n_power_relay       = r_power_relay;
        n_alarm_relay       = r_alarm_relay;
        n_last_heartbeat_ms = r_last_heartbeat_ms;
        n_last_progress_ms  = r_last_progress_ms;
        n_current_mode      = r_current_mode;
        n_last_distance     = r_last_distance;
        n_current_waypoint  = r_current_waypoint;
        n_wrong_way_count   = r_wrong_way_count;
        n_gps1_quality      = r_gps1_quality;
        n_gps2_quality      = r_gps2_quality;
        o_result.mode_request_valid = 1'b0;
        o_result.mode_request       = 8'd0;
        o_result.announce_valid     = 1'b0;
        o_result.announce_mode      = 32'd0;
        o_result.sound_flags        = 6'd0;

        case (i_item.opcode)
            OP_HEARTBEAT: begin
                n_last_heartbeat_ms = i_item.time_ms;
                // A new mode from the rover restarts monitoring.
                if (i_item.vehicle_type == i_cfg.rover_type_code &&
                    i_item.mode_number != r_current_mode) begin
                    o_result.announce_valid = 1'b1;
                    o_result.announce_mode  = i_item.mode_number;
                    n_current_mode     = i_item.mode_number;
                    n_last_progress_ms = 32'd0;
                    n_failed_latch     = 1'b0;
                    n_going_wrong_way  = 1'b0;
                    n_wrong_way_count  = 8'd0;
                    n_power_relay      = 1'b1;
                    n_alarm_relay      = 1'b0;
                end
                if (!r_link_seen) begin
                    n_link_seen = 1'b1;
                    o_result.sound_flags = o_result.sound_flags | SND_LINK_GOOD;
                end
            end
            OP_ITEM_REACHED: begin
                n_last_progress_ms = i_item.time_ms;
            end
            OP_DISTANCE: begin
                // The first distance, a shrinking one, or a steady one while not heading away
                // counts as progress.
                if (!r_distance_known) begin
                    progress = 1'b1;
                end else if (i_item.waypoint_distance == r_last_distance) begin
                    progress = !r_going_wrong_way;
                end else if (i_item.waypoint_distance > r_last_distance) begin
                    n_going_wrong_way = 1'b1;
                    if (r_wrong_way_count != COUNT_MAX) begin
                        n_wrong_way_count = r_wrong_way_count + 8'd1;
                    end
                end else begin
                    progress = 1'b1;
                end
                n_last_distance  = i_item.waypoint_distance;
                n_distance_known = 1'b1;
                if (progress) begin
                    n_last_progress_ms = i_item.time_ms;
                    n_going_wrong_way  = 1'b0;
                    n_wrong_way_count  = 8'd0;
                end
            end
            OP_WAYPOINT: begin
                if (i_item.waypoint_index != r_current_waypoint) begin
                    n_current_waypoint = i_item.waypoint_index;
                    n_distance_known   = 1'b0;
                    n_last_progress_ms = i_item.time_ms;
                end
            end
            OP_GPS1: begin
                n_gps1_quality = i_item.fix_quality;
            end
            OP_GPS2: begin
                n_gps2_quality = i_item.fix_quality;
            end
            OP_TICK: begin
                if (!r_failed_latch) begin
                    // Link loss latches the failure; the auto checks still run.
                    if (link_lost) begin
                        n_failed_latch = 1'b1;
                        n_power_relay  = 1'b0;
                        n_alarm_relay  = 1'b1;
                        n_link_seen    = 1'b0;
                        o_result.sound_flags = o_result.sound_flags |
                                               SND_EMERGENCY | SND_LINK_LOST;
                    end
                    if (is_auto) begin
                        if (gps_lost) begin
                            o_result.mode_request_valid = 1'b1;
                            o_result.mode_request       = i_cfg.hold_mode_code;
                            o_result.sound_flags = o_result.sound_flags | SND_GPS_LOW;
                        end else if (stalled) begin
                            n_failed_latch = 1'b1;
                            n_power_relay  = 1'b0;
                            n_alarm_relay  = 1'b1;
                            o_result.sound_flags = o_result.sound_flags | SND_EMERGENCY;
                        end
                        // The wrong-direction warning sounds once per run.
                        if (r_wrong_way_count == WRONG_WAY_ALERT) begin
                            n_wrong_way_count = r_wrong_way_count + 8'd1;
                            o_result.sound_flags = o_result.sound_flags | SND_WRONG_WAY;
                        end
                    end else if (is_hold && !gps_lost) begin
                        o_result.mode_request_valid = 1'b1;
                        o_result.mode_request       = i_cfg.auto_mode_code;
                    end
                end
                if (!r_ready_announced) begin
                    n_ready_announced = 1'b1;
                    o_result.sound_flags = o_result.sound_flags | SND_READY;
                end
            end
            default: ;
        endcase

        o_result.power_on       = n_power_relay;
        o_result.alarm_on       = n_alarm_relay;
        o_result.mission_failed = n_failed_latch;
    end

    // Monitor state, updated once per processed event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_seen         <= 1'b0;
            r_ready_announced   <= 1'b0;
            r_distance_known    <= 1'b0;
            r_going_wrong_way   <= 1'b0;
            r_failed_latch      <= 1'b0;
            r_power_relay       <= 1'b0;
            r_alarm_relay       <= 1'b0;
            r_last_heartbeat_ms <= 32'd0;
            r_last_progress_ms  <= 32'd0;
            r_current_mode      <= INIT_MODE;
            r_last_distance     <= 16'd0;
            r_current_waypoint  <= 16'd0;
            r_wrong_way_count   <= 8'd0;
            r_gps1_quality      <= 8'd0;
            r_gps2_quality      <= 8'd0;
        end else if (i_fire) begin
            r_link_seen         <= n_link_seen;
            r_ready_announced   <= n_ready_announced;
            r_distance_known    <= n_distance_known;
            r_going_wrong_way   <= n_going_wrong_way;
            r_failed_latch      <= n_failed_latch;
            r_power_relay       <= n_power_relay;
            r_alarm_relay       <= n_alarm_relay;
            r_last_heartbeat_ms <= n_last_heartbeat_ms;
            r_last_progress_ms  <= n_last_progress_ms;
            r_current_mode      <= n_current_mode;
            r_last_distance     <= n_last_distance;
            r_current_waypoint  <= n_current_waypoint;
            r_wrong_way_count   <= n_wrong_way_count;
            r_gps1_quality      <= n_gps1_quality;
            r_gps2_quality      <= n_gps2_quality;
        end
    end

endmodule

// ===== rtl/rover_mission_watchdog.sv =====
// An accepted event waits in the input register; it moves into the result register
// while that register is empty or being drained, and its result is then offered.
// Throughput: one event per cycle while the receiver drains results; the monitor
// state updates in the same cycle that moves an event from the input register
// into the result register.
// Reset (synchronous, active low) empties both registers, restores the
// configuration defaults and clears the monitor state.
module rover_mission_watchdog
    import rmw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_time_ms,
    input  logic [7:0]  i_vehicle_type,
    input  logic [31:0] i_mode_number,
    input  logic [15:0] i_waypoint_distance,
    input  logic [15:0] i_waypoint_index,
    input  logic [7:0]  i_fix_quality,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_power_on,
    output logic        o_alarm_on,
    output logic        o_mission_failed,
    output logic        o_mode_request_valid,
    output logic [7:0]  o_mode_request,
    output logic        o_announce_valid,
    output logic [31:0] o_announce_mode,
    output logic [5:0]  o_sound_flags
);

    t_cfg    cfg;
    t_item   r_item;
    t_result step_result, r_result;
    logic    r_in_valid, r_out_valid;
    logic    advance;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    rmw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // An event moves on when the result register is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.opcode            <= i_opcode;
            r_item.time_ms           <= i_time_ms;
            r_item.vehicle_type      <= i_vehicle_type;
            r_item.mode_number       <= i_mode_number;
            r_item.waypoint_distance <= i_waypoint_distance;
            r_item.waypoint_index    <= i_waypoint_index;
            r_item.fix_quality       <= i_fix_quality;
        end
    end

    rmw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_item),
        .o_result (step_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_power_on           = r_result.power_on;
    assign o_alarm_on           = r_result.alarm_on;
    assign o_mission_failed     = r_result.mission_failed;
    assign o_mode_request_valid = r_result.mode_request_valid;
    assign o_mode_request       = r_result.mode_request;
    assign o_announce_valid     = r_result.announce_valid;
    assign o_announce_mode      = r_result.announce_mode;
    assign o_sound_flags        = r_result.sound_flags;

endmodule

// ===== rtl/rmw_checker.sv =====
`include "rover_mission_watchdog_macros.svh"

module rmw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_power_on,
    input logic        o_alarm_on,
    input logic        o_mission_failed,
    input logic        o_mode_request_valid,
    input logic [7:0]  o_mode_request,
    input logic        o_announce_valid,
    input logic [31:0] o_announce_mode,
    input logic [5:0]  o_sound_flags
);

    // A latched failure always leaves power off and the alarm sounding.
    `RMW_ASSERT_NOW(a_failed_relays, o_out_valid && o_mission_failed, !o_power_on && o_alarm_on)

    // The emergency sound only comes with a latched failure.
    `RMW_ASSERT_NOW(a_emergency_latched, o_out_valid && o_sound_flags[4], o_mission_failed)

    // Request and announcement payloads are zero without their valid bits.
    `RMW_ASSERT_NOW(a_idle_payloads, o_out_valid && !o_mode_request_valid && !o_announce_valid, o_mode_request == 8'd0 && o_announce_mode == 32'd0)

    // A stalled result transaction stays offered.
    `RMW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result transaction keeps its sound flags and relay states.
    `RMW_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_sound_flags) && $stable(o_power_on) && $stable(o_alarm_on))

endmodule

bind rover_mission_watchdog rmw_checker u_rmw_checker (.*);

// ===== test/tb_rover_mission_watchdog.sv =====
module tb_rover_mission_watchdog;
    import rmw_pkg::*;

    // Opcode value that the block does not define; it must leave all state alone.
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int NUM_PHASES = 6;
    localparam int SATURATION_PHASE = 5;
    localparam int PHASE_EVENTS = 70;
    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        t_item   ev;
        bit      typed;
        t_result want;
    } t_step;

    typedef struct {
        logic [15:0] stop_s;
        logic [7:0]  min_fix;
        logic [7:0]  auto_code;
        logic [7:0]  hold_code;
        logic [7:0]  rover_code;
    } t_setting;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_opcode = '0;
    logic [31:0] i_time_ms = '0;
    logic [7:0]  i_vehicle_type = '0;
    logic [31:0] i_mode_number = '0;
    logic [15:0] i_waypoint_distance = '0;
    logic [15:0] i_waypoint_index = '0;
    logic [7:0]  i_fix_quality = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_power_on;
    logic        o_alarm_on;
    logic        o_mission_failed;
    logic        o_mode_request_valid;
    logic [7:0]  o_mode_request;
    logic        o_announce_valid;
    logic [31:0] o_announce_mode;
    logic [5:0]  o_sound_flags;

    rover_mission_watchdog DUT (.*);

    // Configuration as the monitor model sees it.
    logic [15:0] cfg_stop_s = STOP_SECONDS_RST;
    logic [7:0]  cfg_min_fix = MIN_FIX_QUALITY_RST;
    logic [7:0]  cfg_auto = AUTO_MODE_CODE_RST;
    logic [7:0]  cfg_hold = HOLD_MODE_CODE_RST;
    logic [7:0]  cfg_rover = ROVER_TYPE_CODE_RST;

    // Mission state of the monitor model.
    logic        rov_link = 1'b0;
    logic        rov_ready = 1'b0;
    logic [31:0] rov_hb_ms = '0;
    logic [31:0] rov_progress_ms = '0;
    logic [15:0] rov_last_dist = '0;
    logic        rov_dist_known = 1'b0;
    logic        rov_wrong_way = 1'b0;
    logic [7:0]  rov_wrong_count = '0;
    logic        rov_failed = 1'b0;
    logic [31:0] rov_mode = INIT_MODE;
    logic [15:0] rov_waypoint = '0;
    logic [7:0]  rov_fix1 = '0;
    logic [7:0]  rov_fix2 = '0;
    logic        rov_power = 1'b0;
    logic        rov_alarm = 1'b0;

    t_result     report_q [$];
    logic [31:0] clock_ms = '0;
    int unsigned burst_left = 0;
    int unsigned sink_left = 0;
    logic [1:0]  sink_mode = '0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned events_sent = 0;
    int unsigned reports_seen = 0;
    int unsigned trips = 0;
    int unsigned requests = 0;
    int unsigned announcements = 0;

    // Directed events, starting from the reset configuration.
    t_step script [25] = '{
        '{'{OP_TICK, 32'd0, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, SND_READY}},
        '{'{OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF},
          1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 6'd0}},
        '{'{OP_HEARTBEAT, 32'd1000, 8'd10, 32'd10, 16'd0, 16'd0, 8'd0}, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 32'd10, SND_LINK_GOOD}},
        '{'{OP_GPS1, 32'd1100, 8'd0, 32'd0, 16'd0, 16'd0, 8'hFF}, 1'b0, '0},
        '{'{OP_GPS2, 32'd1200, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 32'd2000, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_ITEM_REACHED, 32'd0, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_HEARTBEAT, 32'd49000, 8'd10, 32'd10, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 32'd50000, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_DISTANCE, 32'd50100, 8'd0, 32'd0, 16'd100, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_DISTANCE, 32'd50200, 8'd0, 32'd0, 16'd200, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_DISTANCE, 32'd50300, 8'd0, 32'd0, 16'd300, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 32'd51000, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_GPS1, 32'd51100, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 32'd52000, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_HEARTBEAT, 32'd52100, 8'd10, 32'd4, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_GPS2, 32'd52200, 8'd0, 32'd0, 16'd0, 16'd0, 8'd3}, 1'b0, '0},
        '{'{OP_TICK, 32'd53000, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_HEARTBEAT, 32'd53100, 8'd10, 32'd10, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_WAYPOINT, 32'd54000, 8'd0, 32'd0, 16'd0, 16'hFFFF, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 32'd64000, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
          '{1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 32'd0, SND_EMERGENCY | SND_LINK_LOST}},
        '{'{OP_TICK, 32'd64001, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
          '{1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 32'd0, 6'd0}},
        '{'{OP_HEARTBEAT, 32'd65000, 8'd9, 32'd99, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
        '{'{OP_HEARTBEAT, 32'hFFFF_F000, 8'd10, 32'hFFFF_FF0A, 16'd0, 16'd0, 8'd0},
          1'b0, '0},
        '{'{OP_TICK, 32'h0000_0100, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0}
    };

    // Register settings per phase; phases three and four are drawn at random.
    t_setting presets [NUM_PHASES] = '{
        '{16'd1, 8'd0, 8'd0, 8'd255, 8'd0},
        '{16'd65535, 8'd255, 8'd255, 8'd0, 8'd255},
        '{16'd3, 8'd3, 8'd10, 8'd4, 8'd10},
        '{16'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{16'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{16'd2, 8'd2, 8'd7, 8'd3, 8'd1}
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // A failure latches with the power relay off and the alarm relay on.
    function automatic void trip_failure();
        rov_failed = 1'b1;
        rov_power = 1'b0;
        rov_alarm = 1'b1;
    endfunction

    // Updates the mission state for one event and returns the report it causes.
    function automatic t_result monitor_event(input t_item ev);
        t_result     r;
        logic [31:0] limit_ms;
        logic [31:0] since_hb;
        logic [31:0] since_progress;
        logic [7:0]  best;
        logic        in_auto;
        logic        in_hold;
        logic        lost_link;
        logic        lost_gps;
        logic        stalled;
        logic        moved;
        r = '0;
        case (ev.opcode)
            OP_HEARTBEAT: begin
                rov_hb_ms = ev.time_ms;
                if (ev.vehicle_type == cfg_rover && ev.mode_number != rov_mode) begin
                    r.announce_valid = 1'b1;
                    r.announce_mode = ev.mode_number;
                    rov_mode = ev.mode_number;
                    // A new mode restarts monitoring from scratch.
                    rov_progress_ms = '0;
                    rov_failed = 1'b0;
                    rov_wrong_way = 1'b0;
                    rov_wrong_count = '0;
                    rov_power = 1'b1;
                    rov_alarm = 1'b0;
                end
                if (!rov_link) begin
                    rov_link = 1'b1;
                    r.sound_flags |= SND_LINK_GOOD;
                end
            end
            OP_ITEM_REACHED: begin
                rov_progress_ms = ev.time_ms;
            end
            OP_DISTANCE: begin
                // Shrinking distance is progress; growing distance is wrong way.
                moved = 1'b0;
                if (!rov_dist_known) begin
                    moved = 1'b1;
                end else if (ev.waypoint_distance == rov_last_dist) begin
                    moved = !rov_wrong_way;
                end else if (ev.waypoint_distance > rov_last_dist) begin
                    rov_wrong_way = 1'b1;
                    if (rov_wrong_count != COUNT_MAX) begin
                        rov_wrong_count = rov_wrong_count + 8'd1;
                    end
                end else begin
                    moved = 1'b1;
                end
                rov_last_dist = ev.waypoint_distance;
                rov_dist_known = 1'b1;
                if (moved) begin
                    rov_progress_ms = ev.time_ms;
                    rov_wrong_way = 1'b0;
                    rov_wrong_count = '0;
                end
            end
            OP_WAYPOINT: begin
                if (ev.waypoint_index != rov_waypoint) begin
                    rov_waypoint = ev.waypoint_index;
                    rov_dist_known = 1'b0;
                    rov_progress_ms = ev.time_ms;
                end
            end
            OP_GPS1: begin
                rov_fix1 = ev.fix_quality;
            end
            OP_GPS2: begin
                rov_fix2 = ev.fix_quality;
            end
            OP_TICK: begin
                // Elapsed times wrap modulo 2^32.
                limit_ms = 32'(cfg_stop_s) * 32'(MS_PER_SECOND);
                since_hb = ev.time_ms - rov_hb_ms;
                since_progress = ev.time_ms - rov_progress_ms;
                best = (rov_fix1 > rov_fix2) ? rov_fix1 : rov_fix2;
                in_auto = rov_mode == {24'd0, cfg_auto};
                in_hold = rov_mode == {24'd0, cfg_hold};
                lost_link = rov_link && since_hb >= limit_ms;
                lost_gps = best < cfg_min_fix;
                stalled = rov_progress_ms != 0 && since_progress >= limit_ms;
                if (!rov_failed) begin
                    if (lost_link) begin
                        trip_failure();
                        rov_link = 1'b0;
                        r.sound_flags |= SND_EMERGENCY | SND_LINK_LOST;
                    end
                    if (in_auto) begin
                        if (lost_gps) begin
                            r.mode_request_valid = 1'b1;
                            r.mode_request = cfg_hold;
                            r.sound_flags |= SND_GPS_LOW;
                        end else if (stalled) begin
                            trip_failure();
                            r.sound_flags |= SND_EMERGENCY;
                        end
                        if (rov_wrong_count == WRONG_WAY_ALERT) begin
                            rov_wrong_count = rov_wrong_count + 8'd1;
                            r.sound_flags |= SND_WRONG_WAY;
                        end
                    end else if (in_hold && !lost_gps) begin
                        r.mode_request_valid = 1'b1;
                        r.mode_request = cfg_auto;
                    end
                end
                if (!rov_ready) begin
                    rov_ready = 1'b1;
                    r.sound_flags |= SND_READY;
                end
            end
            default: begin
            end
        endcase
        r.power_on = rov_power;
        r.alarm_on = rov_alarm;
        r.mission_failed = rov_failed;
        return r;
    endfunction

    // Offers one event transaction, waits for it to be taken, then maybe pauses.
    task automatic send_event(input t_item ev, input bit typed, input t_result want);
        t_result calc;
        i_in_valid <= 1'b1;
        i_opcode <= ev.opcode;
        i_time_ms <= ev.time_ms;
        i_vehicle_type <= ev.vehicle_type;
        i_mode_number <= ev.mode_number;
        i_waypoint_distance <= ev.waypoint_distance;
        i_waypoint_index <= ev.waypoint_index;
        i_fix_quality <= ev.fix_quality;
        do @(posedge i_clk); while (!o_in_ready);
        calc = monitor_event(ev);
        report_q.push_back(typed ? want : calc);
        events_sent++;
        if ((calc.sound_flags & SND_EMERGENCY) != 0) trips++;
        if (calc.mode_request_valid) requests++;
        if (calc.announce_valid) announcements++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Lets every outstanding report come back so the block is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes all five registers, one transaction each, back to back.
    task automatic apply_settings(input t_setting s);
        logic [2:0]  regs [5];
        logic [15:0] value [5];
        regs = '{CFG_STOP_SECONDS, CFG_MIN_FIX_QUALITY, CFG_AUTO_MODE_CODE,
                 CFG_HOLD_MODE_CODE, CFG_ROVER_TYPE_CODE};
        value = '{s.stop_s, {8'd0, s.min_fix}, {8'd0, s.auto_code},
                  {8'd0, s.hold_code}, {8'd0, s.rover_code}};
        for (int k = 0; k < 5; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data <= value[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cfg_stop_s = s.stop_s;
        cfg_min_fix = s.min_fix;
        cfg_auto = s.auto_code;
        cfg_hold = s.hold_code;
        cfg_rover = s.rover_code;
    endtask

    function automatic logic [2:0] random_opcode();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return OP_TICK;
        if (pick < 55) return OP_DISTANCE;
        if (pick < 70) return OP_HEARTBEAT;
        if (pick < 77) return OP_GPS1;
        if (pick < 84) return OP_GPS2;
        if (pick < 89) return OP_ITEM_REACHED;
        if (pick < 95) return OP_WAYPOINT;
        return OP_UNUSED;
    endfunction

    // Builds an event of the given kind, with the mission clock moved on and
    // the fields that matter steered toward the interesting values.
    function automatic t_item random_event(input logic [2:0] op);
        t_item       ev;
        int unsigned pick;
        logic [31:0] lim;
        int          v;
        lim = 32'(cfg_stop_s) * 32'(MS_PER_SECOND);
        pick = $urandom_range(0, 99);
        if (pick < 60) clock_ms += $urandom_range(0, lim / 8);
        else if (pick < 88) clock_ms += $urandom_range(0, lim + lim / 4);
        else if (pick >= 97) clock_ms = $urandom();
        ev.opcode = op;
        ev.time_ms = clock_ms;
        ev.vehicle_type = 8'($urandom());
        ev.mode_number = $urandom();
        ev.waypoint_distance = 16'($urandom());
        ev.waypoint_index = 16'($urandom());
        ev.fix_quality = 8'($urandom());
        pick = $urandom_range(0, 99);
        case (op)
            OP_HEARTBEAT: begin
                if ($urandom_range(0, 99) < 85) ev.vehicle_type = cfg_rover;
                if (pick < 45) ev.mode_number = {24'd0, cfg_auto};
                else if (pick < 70) ev.mode_number = {24'd0, cfg_hold};
                else if (pick < 80) ev.mode_number = rov_mode;
                else if (pick < 93) ev.mode_number = $urandom_range(0, 31);
            end
            OP_DISTANCE: begin
                v = int'(rov_last_dist);
                if (pick < 30) v = v;
                else if (pick < 60) v = v + int'($urandom_range(1, 50));
                else if (pick < 85) v = v - int'($urandom_range(1, 50));
                else v = int'($urandom_range(0, 65535));
                if (v > 65535) v = 65535;
                if (v < 0) v = 0;
                ev.waypoint_distance = 16'(v);
            end
            OP_WAYPOINT: begin
                if (pick < 70) ev.waypoint_index = rov_waypoint + 16'd1;
                else if (pick < 85) ev.waypoint_index = rov_waypoint;
            end
            OP_GPS1, OP_GPS2: begin
                if (pick < 70) begin
                    v = int'(cfg_min_fix) + int'($urandom_range(0, 2)) - 1;
                    if (v > 255) v = 255;
                    if (v < 0) v = 0;
                    ev.fix_quality = 8'(v);
                end
            end
            default: begin
            end
        endcase
        return ev;
    endfunction

    // A run of growing distance reports followed by a tick.
    task automatic run_wrong_way(input int count);
        t_item ev;
        int    d;
        d = int'(rov_last_dist);
        if (count > 10) d = int'($urandom_range(0, 1000));
        for (int k = 0; k < count; k++) begin
            ev = random_event(OP_DISTANCE);
            d = d + int'($urandom_range(1, 100));
            if (d > 65535) d = 65535;
            ev.waypoint_distance = 16'(d);
            send_event(ev, 1'b0, '0);
        end
        send_event(random_event(OP_TICK), 1'b0, '0);
    endtask

    // Receiver: always ready, random, or held off for most of a stretch.
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= 2'($urandom_range(0, 2));
            sink_left <= $urandom_range(4, 40);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (sink_left < 3);
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Each report transaction is compared with the oldest outstanding one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (report_q.size() == 0) begin
                $display("%0t: report with none outstanding, sounds %0h", $time,
                         o_sound_flags);
                mismatch_count++;
            end else begin
                want = report_q.pop_front();
                check_field("power_on", 32'(want.power_on), 32'(o_power_on));
                check_field("alarm_on", 32'(want.alarm_on), 32'(o_alarm_on));
                check_field("mission_failed", 32'(want.mission_failed),
                            32'(o_mission_failed));
                check_field("mode_request_valid", 32'(want.mode_request_valid),
                            32'(o_mode_request_valid));
                check_field("mode_request", 32'(want.mode_request), 32'(o_mode_request));
                check_field("announce_valid", 32'(want.announce_valid),
                            32'(o_announce_valid));
                check_field("announce_mode", want.announce_mode, o_announce_mode);
                check_field("sound_flags", 32'(want.sound_flags), 32'(o_sound_flags));
            end
        end
    end

    // Ends the run when no transaction moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_setting    setting;
        t_item       ev;
        int unsigned pick;
        logic [31:0] lim;
        logic [31:0] mark;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed events under the reset configuration.
        foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            setting = presets[ph];
            if (ph == 3) begin
                // Auto and hold share one code here.
                setting.stop_s = 16'($urandom_range(1, 20));
                setting.min_fix = 8'($urandom_range(0, 8));
                setting.auto_code = 8'($urandom());
                setting.hold_code = setting.auto_code;
                setting.rover_code = 8'($urandom());
            end else if (ph == 4) begin
                setting.stop_s = 16'($urandom_range(1, 65535));
                setting.min_fix = 8'($urandom());
                setting.auto_code = 8'($urandom());
                setting.hold_code = 8'($urandom());
                setting.rover_code = 8'($urandom());
            end
            settle();
            apply_settings(setting);
            lim = 32'(cfg_stop_s) * 32'(MS_PER_SECOND);
            // Start a little before the clock wraps.
            clock_ms = 32'd0 - lim * $urandom_range(1, 4);
            if (ph == SATURATION_PHASE) run_wrong_way(270);
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    send_event(random_event(random_opcode()), 1'b0, '0);
                end else if (pick < 88) begin
                    run_wrong_way($urandom_range(2, 4));
                end else begin
                    // Drive in auto, keep the link alive, and tick right at
                    // the no-progress limit.
                    ev = random_event(OP_HEARTBEAT);
                    ev.vehicle_type = cfg_rover;
                    ev.mode_number = {24'd0, cfg_auto};
                    send_event(ev, 1'b0, '0);
                    ev = random_event(OP_WAYPOINT);
                    ev.waypoint_index = rov_waypoint + 16'd1;
                    send_event(ev, 1'b0, '0);
                    mark = ev.time_ms;
                    ev = random_event(OP_HEARTBEAT);
                    ev.vehicle_type = cfg_rover;
                    ev.mode_number = {24'd0, cfg_auto};
                    ev.time_ms = mark + lim - 32'd2;
                    send_event(ev, 1'b0, '0);
                    ev = random_event(OP_TICK);
                    ev.time_ms = mark + lim - 32'd1 + 32'($urandom_range(0, 2));
                    send_event(ev, 1'b0, '0);
                    clock_ms = ev.time_ms;
                end
            end
        end
        settle();

        $display("Sent %0d events over %0d register settings; checked %0d reports.",
                 events_sent, NUM_PHASES + 1, reports_seen);
        $display("Model saw %0d emergency stops, %0d mode requests, %0d announcements.",
                 trips, requests, announcements);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
